/* hw/rtl/pid_awfd_pkg.sv */
// ============================================================================
// pid_awfd_pkg
// Shared types and constants for the PID controller with anti-windup.
// ============================================================================
`default_nettype none
package pid_awfd_pkg;

    localparam int IntegralBitsDefault = 48;
    localparam int ClampBits           = 40;
    localparam int AddrBits            = 5;

    localparam logic [AddrBits-1:0] ADDR_PROP_GAIN  = 5'd0;
    localparam logic [AddrBits-1:0] ADDR_INTEG_GAIN = 5'd4;
    localparam logic [AddrBits-1:0] ADDR_DERIV_GAIN = 5'd8;
    localparam logic [AddrBits-1:0] ADDR_SMOOTHING  = 5'd12;
    localparam logic [AddrBits-1:0] ADDR_WIN_LOW    = 5'd16;
    localparam logic [AddrBits-1:0] ADDR_WIN_HIGH   = 5'd20;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] error_sample;
        logic        [15:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive_value;
        logic               output_saturated;
        logic               integrating;
    } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/pid_antiwindup_filtered_derivative.sv */
// ============================================================================
// pid_antiwindup_filtered_derivative
// PID controller with conditional-integration anti-windup and a smoothed
// derivative, Q16.16 output with saturation.
// ============================================================================
//  channel | direction | payload               | handshake
//  in      | input     | pid_awfd_pkg::in_item_t  | in_valid / in_ready
//  out     | output    | pid_awfd_pkg::out_item_t | out_valid / out_ready
//  cfg     | input     | 32-bit APB registers  | psel/penable/pready
//
// A sample runs a 25-step serial divider for the derivative, then five
// 18-step passes of one shared shift-add multiplier. A clear request zeroes
// the stored terms and registers its result without the divider or
// multiplier. Reset clears all stored terms and sets the integrate flag. A
// stalled result holds in the output register while the next request waits;
// in_ready is low until the result is taken and rises in the next cycle.
`default_nettype none
module pid_antiwindup_filtered_derivative #(
    parameter int INTEGRAL_BITS = pid_awfd_pkg::IntegralBitsDefault
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire pid_awfd_pkg::in_item_t          in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output pid_awfd_pkg::out_item_t              out_item,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pid_awfd_pkg::AddrBits-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    localparam int IB = INTEGRAL_BITS;
    localparam int MW = 42;
    localparam logic signed [63:0] ClampMag = 64'sd1 <<< pid_awfd_pkg::ClampBits;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_MA   = 7'b0000100,
        ST_MB   = 7'b0001000,
        ST_MP   = 7'b0010000,
        ST_MI   = 7'b0100000,
        ST_MD   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] kp_reg, ki_reg, kd_reg;
    logic        [16:0] alpha_reg;
    logic signed [31:0] wlo_reg, whi_reg;

    logic signed [15:0] perr_reg;
    logic signed [IB-1:0] integ_reg;
    logic signed [31:0] deriv_reg;
    logic               inten_reg;

    logic signed [15:0] e_reg;
    logic signed [31:0] q_reg;
    logic signed [63:0] sum_reg;
    logic               busy_out_reg;
    pid_awfd_pkg::out_item_t res_reg;

    logic        wr_en;
    logic [15:0] dt;
    logic signed [IB-1:0] x_ext, imax, imin, isum;
    logic signed [IB:0]   iwide;
    logic signed [63:0]   integ_w;
    logic signed [MW-1:0] ic;
    logic               div_start, div_done;
    logic signed [31:0] div_q;
    logic               mul_start, mul_done;
    logic signed [MW-1:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [MW+17:0] mul_p;
    logic        [16:0] alpha_c;
    logic signed [63:0] sum_fin;
    logic signed [31:0] u;
    logic               sat;

    // Register write and readback
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            alpha_reg <= 17'h10000;
            wlo_reg   <= 32'sh8000_0000;
            whi_reg   <= 32'sh7fff_ffff;
        end
        else if (wr_en)
        begin
            case (paddr)
                pid_awfd_pkg::ADDR_PROP_GAIN:  kp_reg    <= pwdata[15:0];
                pid_awfd_pkg::ADDR_INTEG_GAIN: ki_reg    <= pwdata[15:0];
                pid_awfd_pkg::ADDR_DERIV_GAIN: kd_reg    <= pwdata[15:0];
                pid_awfd_pkg::ADDR_SMOOTHING:  alpha_reg <= pwdata[16:0];
                pid_awfd_pkg::ADDR_WIN_LOW:    wlo_reg   <= pwdata;
                pid_awfd_pkg::ADDR_WIN_HIGH:   whi_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            pid_awfd_pkg::ADDR_PROP_GAIN:  prdata = 32'(kp_reg);
            pid_awfd_pkg::ADDR_INTEG_GAIN: prdata = 32'(ki_reg);
            pid_awfd_pkg::ADDR_DERIV_GAIN: prdata = 32'(kd_reg);
            pid_awfd_pkg::ADDR_SMOOTHING:  prdata = {15'd0, alpha_reg};
            pid_awfd_pkg::ADDR_WIN_LOW:    prdata = wlo_reg;
            pid_awfd_pkg::ADDR_WIN_HIGH:   prdata = whi_reg;
            default:                       prdata = '0;
        endcase
    end

    // Sample accept and saturating integral step
    assign in_ready  = (state_reg == ST_IDLE) && !busy_out_reg;
    assign dt        = (in_item.elapsed_ms == 16'd0) ? 16'd1 : in_item.elapsed_ms;
    assign x_ext     = IB'($signed({1'b0, dt}) * in_item.error_sample);
    assign imax      = {1'b0, {(IB-1){1'b1}}};
    assign imin      = {1'b1, {(IB-1){1'b0}}};
    assign iwide     = {integ_reg[IB-1], integ_reg} + {x_ext[IB-1], x_ext};
    assign isum      = (iwide[IB] != iwide[IB-1]) ? (iwide[IB] ? imin : imax) : iwide[IB-1:0];
    assign div_start = in_valid && in_ready && (in_item.command == pid_awfd_pkg::CMD_SAMPLE);

    pid_awfd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (25'((in_item.error_sample - perr_reg)) <<< 8),
        .divisor  (dt),
        .done     (div_done),
        .quotient (div_q)
    );

    // Integral clamp for the product
    assign integ_w = 64'(integ_reg);

    always_comb
    begin
        if (integ_w > ClampMag)
            ic = MW'(ClampMag);
        else if (integ_w < -ClampMag)
            ic = MW'(-ClampMag);
        else
            ic = MW'(integ_reg);
    end

    assign alpha_c = alpha_reg[16] ? 17'h10000 : alpha_reg;

    // Select multiplier operands per phase
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MA:
            begin
                mul_a = MW'(q_reg);
                mul_b = 18'(alpha_c);
            end
            ST_MB:
            begin
                mul_a = MW'(deriv_reg);
                mul_b = 18'(17'h10000 - alpha_c);
            end
            ST_MP:
            begin
                mul_a = MW'(e_reg);
                mul_b = 18'(kp_reg);
            end
            ST_MI:
            begin
                mul_a = ic;
                mul_b = 18'(ki_reg);
            end
            ST_MD:
            begin
                mul_a = MW'(deriv_reg);
                mul_b = 18'(kd_reg);
            end
            default: ;
        endcase
    end

    logic mul_go_reg;
    assign mul_start = mul_go_reg;

    pid_awfd_mult #(.AW(MW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign sum_fin = sum_reg + 64'(mul_p >>> 8);
    assign sat     = (sum_fin > 64'sd2147483647) || (sum_fin < -64'sd2147483648);
    assign u       = (sum_fin > 64'sd2147483647) ? 32'sh7fff_ffff :
                     (sum_fin < -64'sd2147483648) ? 32'sh8000_0000 : sum_fin[31:0];

    // Sequence phases
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (div_start) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_MA;
            ST_MA:   if (mul_done) state_next = ST_MB;
            ST_MB:   if (mul_done) state_next = ST_MP;
            ST_MP:   if (mul_done) state_next = ST_MI;
            ST_MI:   if (mul_done) state_next = ST_MD;
            ST_MD:   if (mul_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            perr_reg     <= '0;
            integ_reg    <= '0;
            deriv_reg    <= '0;
            inten_reg    <= 1'b1;
            busy_out_reg <= 1'b0;
            mul_go_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mul_go_reg <= (state_reg == ST_DIV && div_done) ||
                          (mul_done && state_reg != ST_MD);
            if (busy_out_reg && out_ready)
                busy_out_reg <= 1'b0;
            if (in_valid && in_ready)
            begin
                if (in_item.command == pid_awfd_pkg::CMD_CLEAR)
                begin
                    perr_reg     <= '0;
                    integ_reg    <= '0;
                    deriv_reg    <= '0;
                    busy_out_reg <= 1'b1;
                end
                else
                begin
                    perr_reg <= in_item.error_sample;
                    if (inten_reg)
                        integ_reg <= isum;
                end
            end
            if (state_reg == ST_MB && mul_done)
                deriv_reg <= 32'((sum_reg + 64'(mul_p)) >>> 16);
            if (state_reg == ST_MD && mul_done)
            begin
                inten_reg    <= (wlo_reg < u) && (u < whi_reg);
                busy_out_reg <= 1'b1;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (div_start)
            e_reg <= in_item.error_sample;
        if (div_done)
            q_reg <= div_q;
        if (state_reg == ST_MA && mul_done)
            sum_reg <= 64'(mul_p);
        if (state_reg == ST_MB && mul_done)
            sum_reg <= '0;
        if ((state_reg == ST_MP || state_reg == ST_MI) && mul_done)
            sum_reg <= sum_reg + 64'(mul_p);
        if (in_valid && in_ready && in_item.command == pid_awfd_pkg::CMD_CLEAR)
            res_reg <= '{drive_value: '0, output_saturated: 1'b0, integrating: inten_reg};
        if (state_reg == ST_MD && mul_done)
            res_reg <= '{drive_value: u, output_saturated: sat,
                         integrating: (wlo_reg < u) && (u < whi_reg)};
    end

    assign out_valid = busy_out_reg;
    assign out_item  = res_reg;

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("accept while busy");
    a_result_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_IDLE)) else $error("result while working");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.command == pid_awfd_pkg::CMD_CLEAR)
        |=> (integ_reg == '0 && deriv_reg == '0)) else $error("clear failed");
endmodule
`default_nettype wire

/* hw/rtl/pid_awfd_divider.sv */
// ============================================================================
// pid_awfd_divider
// Restoring divider, one quotient bit per cycle, signed truncating quotient.
// ============================================================================
`default_nettype none
module pid_awfd_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [24:0] dividend,
    input  wire logic        [15:0] divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);
    logic [24:0] rem_reg, rem_next;
    logic [24:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] trial;

    assign trial = {rem_reg, quo_reg[24]} - {10'd0, dsr_reg};

    // Shift one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[24] ? 25'(-dividend) : 25'(dividend);
            neg_next  = dividend[24];
            dsr_next  = divisor;
            cnt_next  = 5'd24;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[25])
                rem_next = trial[24:0];
            else
                rem_next = {rem_reg[23:0], quo_reg[24]};
            quo_next = {quo_reg[23:0], ~trial[25]};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -32'(signed'({1'b0, quo_reg})) : 32'(signed'({1'b0, quo_reg}));
endmodule
`default_nettype wire

/* hw/rtl/pid_awfd_mult.sv */
// ============================================================================
// pid_awfd_mult
// Shift-add multiplier, signed 18-bit multiplier by signed wide multiplicand,
// one multiplier bit per cycle.
// ============================================================================
`default_nettype none
module pid_awfd_mult #(
    parameter int AW = 42
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [AW-1:0] mcand,
    input  wire logic signed [17:0]   mplier,
    output logic                      done,
    output logic signed [AW+17:0]     product
);
    localparam int PW = AW + 18;

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mc_reg, mc_next;
    logic        [17:0]   mp_reg, mp_next;
    logic        [4:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Add the shifted multiplicand for each set bit; top bit weighs negative
    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = PW'(mcand);
            mp_next   = mplier;
            cnt_next  = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
                acc_next = (cnt_reg == 5'd0) ? acc_reg - mc_reg : acc_reg + mc_reg;
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire
